/* src/hnm_pkg.sv */
package hnm_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COORD_W = 12;
    localparam int SIZE_W = 13;
    localparam int GAIN_W = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int MEM_ADDR_W = $clog2(MAX_WIDTH);

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUMP_GAIN = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_MIN = 13'd3;
    localparam logic [SIZE_W-1:0] WIDTH_MAX = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd512;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd512;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd2048;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 14'd8192;
    localparam logic [20:0] DEPTH_UNIT = 21'd65280;

    localparam logic [1:0] COMP_RED = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN,
        ST_MUL,
        ST_SQ,
        ST_SUM,
        ST_PM,
        ST_PM2,
        ST_MM,
        ST_PP,
        ST_LHS,
        ST_CMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic win;
        logic mul;
        logic sq;
        logic sum;
        logic pm;
        logic pm2;
        logic mm;
        logic pp;
        logic lhs;
        logic cmp;
        logic emit_adv;
    } cmd_t;

    typedef struct packed {
        logic has_result;
        logic bit_last;
        logic comp_last;
        logic slot_valid;
        logic slot_last;
    } sts_t;

endpackage

/* src/hnm_if.sv */
interface hnm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink (input valid, input height_sample, output ready);
endinterface

interface hnm_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  normal_red;
    logic [7:0]  normal_green;
    logic [7:0]  normal_blue;
    logic        run_last;

    modport source (output valid, output pixel_x, output pixel_y, output normal_red,
                    output normal_green, output normal_blue, output run_last,
                    input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input normal_red,
                  input normal_green, input normal_blue, input run_last,
                  output ready);
endinterface

/* src/hnm_ctrl.sv */
module hnm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  hnm_pkg::sts_t  sts,
    output hnm_pkg::cmd_t  cmd
);

    hnm_pkg::state_t state_reg;
    hnm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hnm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hnm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hnm_pkg::ST_WIN;
                end
            end
            hnm_pkg::ST_WIN:
            begin
                state_next = sts.has_result ? hnm_pkg::ST_MUL : hnm_pkg::ST_IDLE;
            end
            hnm_pkg::ST_MUL: state_next = hnm_pkg::ST_SQ;
            hnm_pkg::ST_SQ:  state_next = hnm_pkg::ST_SUM;
            hnm_pkg::ST_SUM: state_next = hnm_pkg::ST_PM;
            hnm_pkg::ST_PM:  state_next = hnm_pkg::ST_PM2;
            hnm_pkg::ST_PM2: state_next = hnm_pkg::ST_MM;
            hnm_pkg::ST_MM:  state_next = hnm_pkg::ST_PP;
            hnm_pkg::ST_PP:  state_next = hnm_pkg::ST_LHS;
            hnm_pkg::ST_LHS: state_next = hnm_pkg::ST_CMP;
            hnm_pkg::ST_CMP:
            begin
                if (!sts.bit_last)
                begin
                    state_next = hnm_pkg::ST_MM;
                end
                else if (!sts.comp_last)
                begin
                    state_next = hnm_pkg::ST_PM;
                end
                else
                begin
                    state_next = hnm_pkg::ST_EMIT;
                end
            end
            hnm_pkg::ST_EMIT:
            begin
                if (sts.slot_valid && out_ready && sts.slot_last)
                begin
                    state_next = hnm_pkg::ST_IDLE;
                end
            end
            default: state_next = hnm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            hnm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.accept = in_valid;
            end
            hnm_pkg::ST_WIN: cmd.win = 1'b1;
            hnm_pkg::ST_MUL: cmd.mul = 1'b1;
            hnm_pkg::ST_SQ:  cmd.sq = 1'b1;
            hnm_pkg::ST_SUM: cmd.sum = 1'b1;
            hnm_pkg::ST_PM:  cmd.pm = 1'b1;
            hnm_pkg::ST_PM2: cmd.pm2 = 1'b1;
            hnm_pkg::ST_MM:  cmd.mm = 1'b1;
            hnm_pkg::ST_PP:  cmd.pp = 1'b1;
            hnm_pkg::ST_LHS: cmd.lhs = 1'b1;
            hnm_pkg::ST_CMP: cmd.cmp = 1'b1;
            hnm_pkg::ST_EMIT:
            begin
                out_valid = sts.slot_valid;
                // skip slots with no copy, hold on a stalled beat
                cmd.emit_adv = !sts.slot_valid || out_ready;
            end
            default: cmd = '0;
        endcase
    end

endmodule

/* src/hnm_datapath.sv */
module hnm_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [7:0]                           sample_in,
    input  logic                                 cfg_we,
    input  logic [hnm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hnm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  hnm_pkg::cmd_t                        cmd,
    output hnm_pkg::sts_t                        sts,
    output logic [hnm_pkg::COORD_W-1:0]          pixel_x,
    output logic [hnm_pkg::COORD_W-1:0]          pixel_y,
    output logic [7:0]                           normal_red,
    output logic [7:0]                           normal_green,
    output logic [7:0]                           normal_blue
);

    localparam logic [31:0] DEPTH_SQ = 32'd65280 * 32'd65280;

    logic [7:0] upper_mem [hnm_pkg::MAX_WIDTH];
    logic [7:0] middle_mem [hnm_pkg::MAX_WIDTH];

    logic [hnm_pkg::SIZE_W-1:0]  width_reg;
    logic [hnm_pkg::SIZE_W-1:0]  height_reg;
    logic [hnm_pkg::GAIN_W-1:0]  gain_reg;
    logic [hnm_pkg::COORD_W-1:0] col_reg;
    logic [hnm_pkg::COORD_W-1:0] row_reg;
    logic [7:0]                  sample_reg;
    logic [7:0]                  up_reg;
    logic [7:0]                  mid_reg;
    logic [7:0]                  win_reg [9];
    logic [hnm_pkg::COORD_W-1:0] x_reg;
    logic [hnm_pkg::COORD_W-1:0] y_reg;
    logic signed [22:0]          ax_reg;
    logic signed [22:0]          ay_reg;
    logic [41:0]                 sqx_reg;
    logic [41:0]                 sqy_reg;
    logic [43:0]                 s_reg;
    logic [1:0]                  comp_reg;
    logic [2:0]                  bit_reg;
    logic [7:0]                  k_reg;
    logic                        pneg_reg;
    logic                        pzero_reg;
    logic [29:0]                 pm_reg;
    logic [59:0]                 rhs_reg;
    logic [16:0]                 mm2_reg;
    logic [7:0]                  trial_reg;
    logic                        mle_reg;
    logic [38:0]                 lo_reg;
    logic [38:0]                 hi_reg;
    logic [60:0]                 lhs_reg;
    logic [7:0]                  red_reg;
    logic [7:0]                  green_reg;
    logic [7:0]                  blue_reg;
    logic [3:0]                  slot_reg;

    logic [hnm_pkg::SIZE_W-1:0]  w_eff;
    logic [hnm_pkg::SIZE_W-1:0]  h_eff;
    logic [hnm_pkg::GAIN_W-1:0]  g_eff;
    logic [hnm_pkg::COORD_W-1:0] w_m1;
    logic [hnm_pkg::COORD_W-1:0] w_m2;
    logic [hnm_pkg::COORD_W-1:0] h_m1;
    logic [hnm_pkg::COORD_W-1:0] h_m2;
    logic signed [8:0]           dx;
    logic signed [8:0]           dy;
    logic [20:0]                 ax_mag;
    logic [20:0]                 ay_mag;
    logic [20:0]                 mag_sel;
    logic                        neg_sel;
    logic [7:0]                  trial;
    logic [8:0]                  mm;
    logic                        ok;
    logic [7:0]                  k_new;
    logic [8:0]                  mask;
    logic                        col_wrap;
    logic                        row_wrap;
    logic                        at_x1;
    logic                        at_xr;
    logic                        at_y1;
    logic                        at_yb;

    always_comb
    begin
        if (width_reg < hnm_pkg::SIZE_MIN)
            w_eff = hnm_pkg::SIZE_MIN;
        else if (width_reg > hnm_pkg::WIDTH_MAX)
            w_eff = hnm_pkg::WIDTH_MAX;
        else
            w_eff = width_reg;
        if (height_reg < hnm_pkg::SIZE_MIN)
            h_eff = hnm_pkg::SIZE_MIN;
        else if (height_reg > hnm_pkg::HEIGHT_MAX)
            h_eff = hnm_pkg::HEIGHT_MAX;
        else
            h_eff = height_reg;
        g_eff = (gain_reg > hnm_pkg::GAIN_MAX) ? hnm_pkg::GAIN_MAX : gain_reg;
    end

    assign w_m1 = hnm_pkg::COORD_W'(w_eff - 13'd1);
    assign w_m2 = hnm_pkg::COORD_W'(w_eff - 13'd2);
    assign h_m1 = hnm_pkg::COORD_W'(h_eff - 13'd1);
    assign h_m2 = hnm_pkg::COORD_W'(h_eff - 13'd2);

    assign col_wrap = ({1'b0, col_reg} + 13'd1) >= w_eff;
    assign row_wrap = ({1'b0, row_reg} + 13'd1) >= h_eff;

    assign dx = $signed({1'b0, win_reg[5]}) - $signed({1'b0, win_reg[3]});
    assign dy = $signed({1'b0, win_reg[7]}) - $signed({1'b0, win_reg[1]});

    assign ax_mag = ax_reg[22] ? 21'(-ax_reg) : ax_reg[20:0];
    assign ay_mag = ay_reg[22] ? 21'(-ay_reg) : ay_reg[20:0];

    // p is -ax, -ay or the depth unit
    always_comb
    begin
        case (comp_reg)
            hnm_pkg::COMP_RED:
            begin
                mag_sel = ax_mag;
                neg_sel = !ax_reg[22] && (ax_reg != '0);
            end
            hnm_pkg::COMP_GREEN:
            begin
                mag_sel = ay_mag;
                neg_sel = !ay_reg[22] && (ay_reg != '0);
            end
            default:
            begin
                mag_sel = hnm_pkg::DEPTH_UNIT;
                neg_sel = 1'b0;
            end
        endcase
    end

    assign trial = k_reg | (8'd1 << bit_reg);
    assign mm = trial[7] ? {1'b0, trial[6:0], 1'b0} : (9'd256 - {trial, 1'b0});

    always_comb
    begin
        if (mle_reg)
            ok = !pneg_reg || (lhs_reg >= 61'(rhs_reg));
        else
            ok = !pneg_reg && !pzero_reg && (lhs_reg <= 61'(rhs_reg));
    end

    assign k_new = ok ? trial_reg : k_reg;

    assign at_x1 = x_reg == 12'd1;
    assign at_xr = x_reg == w_m2;
    assign at_y1 = y_reg == 12'd1;
    assign at_yb = y_reg == h_m2;
    assign mask = {at_xr && at_yb, at_x1 && at_yb, at_xr && at_y1, at_x1 && at_y1,
                   at_xr, at_x1, at_yb, at_y1, 1'b1};

    always_comb
    begin
        case (slot_reg)
            4'd0:    begin pixel_x = x_reg;  pixel_y = y_reg;  end
            4'd1:    begin pixel_x = x_reg;  pixel_y = '0;     end
            4'd2:    begin pixel_x = x_reg;  pixel_y = h_m1;   end
            4'd3:    begin pixel_x = '0;     pixel_y = y_reg;  end
            4'd4:    begin pixel_x = w_m1;   pixel_y = y_reg;  end
            4'd5:    begin pixel_x = '0;     pixel_y = '0;     end
            4'd6:    begin pixel_x = w_m1;   pixel_y = '0;     end
            4'd7:    begin pixel_x = '0;     pixel_y = h_m1;   end
            default: begin pixel_x = w_m1;   pixel_y = h_m1;   end
        endcase
    end

    assign normal_red = red_reg;
    assign normal_green = green_reg;
    assign normal_blue = blue_reg;

    assign sts.has_result = (col_reg >= 12'd2) && (row_reg >= 12'd2);
    assign sts.bit_last = bit_reg == 3'd0;
    assign sts.comp_last = comp_reg == hnm_pkg::COMP_BLUE;
    assign sts.slot_valid = (slot_reg <= 4'd8) && mask[slot_reg];
    assign sts.slot_last = ((mask >> slot_reg) >> 1) == 9'd0;

    // line stores: read on accept, write back in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            up_reg <= upper_mem[col_reg];
            mid_reg <= middle_mem[col_reg];
        end
        if (cmd.win)
        begin
            upper_mem[col_reg] <= mid_reg;
            middle_mem[col_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= hnm_pkg::WIDTH_RESET;
            height_reg <= hnm_pkg::HEIGHT_RESET;
            gain_reg <= hnm_pkg::GAIN_RESET;
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hnm_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[hnm_pkg::SIZE_W-1:0];
                    col_reg <= '0;
                    row_reg <= '0;
                end
                hnm_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data[hnm_pkg::SIZE_W-1:0];
                    col_reg <= '0;
                    row_reg <= '0;
                end
                hnm_pkg::CFG_BUMP_GAIN: gain_reg <= cfg_data;
                default: ;
            endcase
        end
        else if (cmd.win)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3] <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= up_reg;
            win_reg[5] <= mid_reg;
            win_reg[8] <= sample_reg;
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + 12'd1;
            end
            else
            begin
                col_reg <= col_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            sample_reg <= sample_in;
        if (cmd.win)
        begin
            x_reg <= col_reg - 12'd1;
            y_reg <= row_reg - 12'd1;
            slot_reg <= '0;
        end
        if (cmd.mul)
        begin
            ax_reg <= dx * $signed({1'b0, g_eff});
            ay_reg <= dy * $signed({1'b0, g_eff});
        end
        if (cmd.sq)
        begin
            sqx_reg <= ax_mag * ax_mag;
            sqy_reg <= ay_mag * ay_mag;
        end
        if (cmd.sum)
        begin
            s_reg <= 44'(sqx_reg) + 44'(sqy_reg) + 44'(DEPTH_SQ);
            comp_reg <= hnm_pkg::COMP_RED;
            bit_reg <= 3'd7;
            k_reg <= '0;
        end
        if (cmd.pm)
        begin
            pm_reg <= 30'(mag_sel) * 30'd255;
            pneg_reg <= neg_sel;
            pzero_reg <= mag_sel == '0;
        end
        if (cmd.pm2)
            rhs_reg <= pm_reg * pm_reg;
        if (cmd.mm)
        begin
            mm2_reg <= mm * mm;
            trial_reg <= trial;
            mle_reg <= !trial[7] || (trial == 8'd128);
        end
        if (cmd.pp)
        begin
            lo_reg <= mm2_reg * s_reg[21:0];
            hi_reg <= mm2_reg * s_reg[43:22];
        end
        if (cmd.lhs)
            lhs_reg <= 61'(lo_reg) + (61'(hi_reg) << 22);
        if (cmd.cmp)
        begin
            if (bit_reg == 3'd0)
            begin
                case (comp_reg)
                    hnm_pkg::COMP_RED:   red_reg <= k_new;
                    hnm_pkg::COMP_GREEN: green_reg <= k_new;
                    default:             blue_reg <= k_new;
                endcase
                comp_reg <= comp_reg + 2'd1;
                bit_reg <= 3'd7;
                k_reg <= '0;
            end
            else
            begin
                k_reg <= k_new;
                bit_reg <= bit_reg - 3'd1;
            end
        end
        if (cmd.emit_adv)
            slot_reg <= slot_reg + 4'd1;
    end

endmodule

/* src/height_to_normal_map_core.sv */
// Channel  Dir  Payload
// in_ch    in   height_sample
// out_ch   out  pixel_x, pixel_y, normal_red, normal_green, normal_blue, run_last
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A sample in the first two rows or columns of a frame yields no output.
// A sample that completes a window is worked on until its last output beat is taken:
// the normalizing search runs 8 trial steps for each of 3 colours on one multiplier
// chain, then up to 9 slots are walked one a cycle, holding on an output stall.
// Reset clears the window, counters and state machine; line stores hold no reset.
// An output stall holds the current beat and blocks new samples.
module height_to_normal_map_core (
    input  logic                              clk,
    input  logic                              rst_n,
    hnm_in_if.sink                            in_ch,
    hnm_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [hnm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hnm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    hnm_pkg::cmd_t cmd;
    hnm_pkg::sts_t sts;

    hnm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hnm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_in    (in_ch.height_sample),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .pixel_x      (out_ch.pixel_x),
        .pixel_y      (out_ch.pixel_y),
        .normal_red   (out_ch.normal_red),
        .normal_green (out_ch.normal_green),
        .normal_blue  (out_ch.normal_blue)
    );

    assign out_ch.run_last = sts.slot_last;

endmodule

/* src/hnm_checker.sv */
module hnm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic run_last
);

    // never take a sample while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output valid");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after accepted beat");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_last) |=> !in_ready)
        else $error("input reopened before last result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output beat dropped while stalled");

endmodule

bind height_to_normal_map_core hnm_checker u_hnm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .run_last  (out_ch.run_last)
);
